>>> hw/rtl/pcbd_pkg.sv
// Package for the prefix code bit decoder: sizes, operation codes and the
// structs passed between the table, the output buffer and the top level.
// No dependencies.
`default_nettype none

package pcbd_pkg;

    // Table and code sizes.
    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_CODE_LEN  = 16;
    localparam int CODE_W        = 16;
    localparam int LEN_W         = 5;
    localparam int SYM_W         = 8;
    localparam int IDX_W         = 4;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(MAX_CODE_LEN + 1);

    // Packed widths of the stream words.
    localparam int IN_FIELDS_W = IDX_W + CODE_W + LEN_W + SYM_W + 1;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((SYM_W + 7) / 8) * 8;

    // Operation carried in the input tuser.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Result status carried in the output tuser.
    localparam logic ST_SYMBOL = 1'b0;
    localparam logic ST_ERROR  = 1'b1;

    // One table write.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [SYM_W-1:0]  sym;
    } t_entry_wr;

    // Outcome of the parallel match.
    typedef struct packed {
        logic             found;
        logic [SYM_W-1:0] sym;
    } t_match;

    // One result word.
    typedef struct packed {
        logic             status;
        logic [SYM_W-1:0] sym;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/prefix_code_bit_decoder.sv
// Top level of the prefix code bit decoder: pending code register, table
// match and result buffer. Depends on pcbd_pkg, pcbd_table, pcbd_out_buf.
//
//  Channel  Direction  tdata (low bit up)                               tuser      tlast
//  s_axis   in         index[3:0] code[19:4] length[24:20]              operation  last_bit
//                      symbol[32:25] code_bit[33], zero pad to 40
//  m_axis   out        symbol[7:0]                                      status     -
//
// One word is taken per cycle while s_axis_tready is high; a decode word's match against
// all table slots runs in the cycle it is accepted and its result is registered at that edge.
// With m_axis ready, a result is visible in the cycle after its word was accepted.
// s_axis_tready is low while the skid word is held, which follows a stalled m_axis
// with the output word already occupied.
// Synchronous active-low reset empties the table, the pending code and the buffer.
`default_nettype none

module prefix_code_bit_decoder
    import pcbd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // index, code, length, symbol, code_bit
    input  wire logic                  s_axis_tuser,   // operation
    input  wire logic                  s_axis_tlast,   // last_bit
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // symbol
    output logic                       m_axis_tuser    // status
);

    localparam int IDX_LO  = 0;
    localparam int CODE_LO = IDX_LO + IDX_W;
    localparam int LEN_LO  = CODE_LO + CODE_W;
    localparam int SYM_LO  = LEN_LO + LEN_W;
    localparam int BIT_LO  = SYM_LO + SYM_W;

    logic [CODE_W-1:0] r_pend_bits, n_pend_bits;
    logic [CNT_W-1:0]  r_pend_count, n_pend_count;

    logic              accept;
    logic              is_decode;
    logic [IDX_W-1:0]  in_index;
    logic [CODE_W-1:0] cand_bits;
    logic [CNT_W-1:0]  cand_count;
    logic              err;
    logic              push;
    logic              buf_full;
    t_entry_wr         wr;
    t_match            match;
    t_result           result;
    t_result           out_result;

    assign s_axis_tready = !buf_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_decode     = (s_axis_tuser == OP_DECODE);
    assign in_index      = s_axis_tdata[IDX_LO +: IDX_W];

    // Table write from a load word; slots past the table are dropped.
    always_comb begin
        wr.en   = accept && !is_decode
               && ({{(32 - IDX_W){1'b0}}, in_index} < 32'(TABLE_ENTRIES));
        wr.slot = SLOT_W'(in_index);
        wr.code = s_axis_tdata[CODE_LO +: CODE_W];
        wr.len  = s_axis_tdata[LEN_LO +: LEN_W];
        wr.sym  = s_axis_tdata[SYM_LO +: SYM_W];
    end

    // Candidate code with the new bit shifted in.
    assign cand_bits  = {r_pend_bits[CODE_W-2:0], s_axis_tdata[BIT_LO]};
    assign cand_count = r_pend_count + CNT_W'(1);

    pcbd_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_cand_bits  (cand_bits),
        .i_cand_count (cand_count),
        .o_match      (match)
    );

    // A full-length candidate without a match is an error.
    assign err  = !match.found && (cand_count >= CNT_W'(MAX_CODE_LEN));
    assign push = accept && is_decode && (match.found || err);

    always_comb begin
        result.status = match.found ? ST_SYMBOL : ST_ERROR;
        result.sym    = match.found ? match.sym : '0;
    end

    // Pending code update; any result or the last bit clears it.
    always_comb begin
        n_pend_bits  = r_pend_bits;
        n_pend_count = r_pend_count;
        if (accept && is_decode) begin
            if (match.found || err || s_axis_tlast) begin
                n_pend_bits  = '0;
                n_pend_count = '0;
            end else begin
                n_pend_bits  = cand_bits;
                n_pend_count = cand_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits  <= '0;
            r_pend_count <= '0;
        end else begin
            r_pend_bits  <= n_pend_bits;
            r_pend_count <= n_pend_count;
        end
    end

    pcbd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result),
        .o_full   (buf_full)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - SYM_W){1'b0}}, out_result.sym};
    assign m_axis_tuser = out_result.status;

    // The pending count never holds a full-length code.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_count < CNT_W'(MAX_CODE_LEN))
        else $error("pending count reached maximum code length");

    // A decode word carrying the last bit leaves no pending code.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_decode && s_axis_tlast) |=> (r_pend_count == '0))
        else $error("pending code survived a last bit");

    // An error result carries a zero symbol.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_ERROR)) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero symbol");

endmodule

`default_nettype wire

>>> hw/rtl/pcbd_table.sv
// Code table storage with a parallel match of the candidate code against
// every entry; the lowest matching slot wins. Depends on pcbd_pkg.
`default_nettype none

module pcbd_table
    import pcbd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_entry_wr         i_wr,
    input  wire logic [CODE_W-1:0] i_cand_bits,
    input  wire logic [CNT_W-1:0]  i_cand_count,
    output t_match                 o_match
);

    logic [CODE_W-1:0] r_code [TABLE_ENTRIES];
    logic [LEN_W-1:0]  r_len  [TABLE_ENTRIES];
    logic [SYM_W-1:0]  r_sym  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hit;

    // Lengths reset to zero so every slot starts empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_len[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_len[i_wr.slot] <= i_wr.len;
        end
    end

    // Code and symbol are only read behind a nonzero length.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_code[i_wr.slot] <= i_wr.code;
            r_sym[i_wr.slot]  <= i_wr.sym;
        end
    end

    // Per-slot compare of the low len bits; equal length bounds len to the code width.
    always_comb begin
        logic [CODE_W-1:0] mask;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            mask   = ~({CODE_W{1'b1}} << r_len[i]);
            hit[i] = (r_len[i] != '0)
                  && (32'(r_len[i]) == 32'(i_cand_count))
                  && (((i_cand_bits ^ r_code[i]) & mask) == '0);
        end
    end

    // Priority select, lowest slot first.
    always_comb begin
        o_match.found = 1'b0;
        o_match.sym   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_match.found = 1'b1;
                o_match.sym   = r_sym[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pcbd_out_buf.sv
// Two-word output buffer: an output register plus a skid register, so the
// input side sees a registered ready. Depends on pcbd_pkg.
`default_nettype none

module pcbd_out_buf
    import pcbd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_result,
    output logic         o_full
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_out_valid && i_ready;

    // Refill the output word from the skid word, then place a new word.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (i_push) begin
            if (!n_out_valid) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload words.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_full   = r_skid_valid;

    // The skid word is only ever filled behind a held output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    // A stalled output word with a push must land in the skid word.
    a_push_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && i_push) |=> r_skid_valid)
        else $error("pushed word lost while output stalled");

    // A popped output word with a pending skid word is replaced at once.
    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_skid_valid) |=> r_out_valid)
        else $error("output word not refilled from skid word");

endmodule

`default_nettype wire
